@@ src/wpaa_pkg.sv @@
package wpaa_pkg;

	localparam int SAMPLE_BITS  = 16;
	localparam int SQP_BITS     = 2 * SAMPLE_BITS - 1;
	localparam int PRODP_BITS   = 2 * SAMPLE_BITS;
	localparam int SQ_BITS      = 2 * SAMPLE_BITS + 5;
	localparam int PROD_BITS    = 2 * SAMPLE_BITS + 6;
	localparam int WSQ_BITS     = SQ_BITS + 7;
	localparam int WPROD_BITS   = PROD_BITS + 7;
	localparam int MAX_WINDOW   = 128;
	localparam int POS_BITS     = 7;
	localparam int FILL_BITS    = 8;
	localparam int WLEN_BITS    = 8;
	localparam int XY_BITS      = 48;
	localparam int Z_BITS       = 32;
	localparam int CORDIC_STEPS = 22;
	localparam int STEP_BITS    = 5;
	localparam int ANGLE_BITS   = 16;
	localparam int ANGLE_LIMIT  = 23040;
	localparam int WLEN_RESET   = 50;

	localparam logic [SQ_BITS-1:0] SQ_MAX = {SQ_BITS{1'b1}};
	localparam logic signed [PROD_BITS-1:0] PROD_MAX = {1'b0, {(PROD_BITS-1){1'b1}}};
	localparam logic signed [PROD_BITS-1:0] PROD_MIN = {1'b1, {(PROD_BITS-1){1'b0}}};

	localparam logic signed [Z_BITS-1:0] Z_DEG90  = Z_BITS'(90 * 65536);
	localparam logic signed [Z_BITS-1:0] Z_DEG180 = Z_BITS'(180 * 65536);

	// One completed depth sample handed from the front to the back.
	typedef struct packed {
		logic [SQ_BITS-1:0]          sq_a;
		logic [SQ_BITS-1:0]          sq_b;
		logic signed [PROD_BITS-1:0] prod;
		logic                        clr;
	} q_entry_t;

	// Arctangent of 2^-i in units of 2^-16 degree.
	function automatic logic signed [Z_BITS-1:0] atan_step(input logic [STEP_BITS-1:0] i);
		logic signed [Z_BITS-1:0] r;
		unique case (i)
			5'd0:  r = 32'sd2949120;
			5'd1:  r = 32'sd1740967;
			5'd2:  r = 32'sd919879;
			5'd3:  r = 32'sd466945;
			5'd4:  r = 32'sd234379;
			5'd5:  r = 32'sd117304;
			5'd6:  r = 32'sd58666;
			5'd7:  r = 32'sd29335;
			5'd8:  r = 32'sd14668;
			5'd9:  r = 32'sd7334;
			5'd10: r = 32'sd3667;
			5'd11: r = 32'sd1833;
			5'd12: r = 32'sd917;
			5'd13: r = 32'sd458;
			5'd14: r = 32'sd229;
			5'd15: r = 32'sd115;
			5'd16: r = 32'sd57;
			5'd17: r = 32'sd29;
			5'd18: r = 32'sd14;
			5'd19: r = 32'sd7;
			5'd20: r = 32'sd4;
			5'd21: r = 32'sd2;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

@@ src/windowed_principal_axis_angle_unit.sv @@
// Windowed principal-axis angle of an intercept/gradient cross-plot.
// Input beats on s_axis carry one trace of one depth sample; tlast marks the
// last trace of the sample. Each trace adds A*A, B*B and A*B to trace sums.
// At the last trace the sums enter a 128-entry ring and one result beat
// leaves on m_axis: the angle 0.5*atan2(2*AB, A2-B2) over the newest
// window_len samples, in 1/256 degree, and a window-full flag.
// window_len comes on the cfg channel (always ready); the user must write it
// only while idle; the block does not enforce this. Timing: a non-last trace
// is taken every cycle unless a last trace ahead of it waits for queue room.
// A last trace is pushed into the two-sample queue once it has room; the back
// then sums n samples of the ring through its single read port, n being
// min(window_len, samples since clear, 128) with a window_len of 0 taken as
// 1, sets up, normalizes, runs 22 CORDIC rotation steps and rounds; normalize
// and rotation are skipped when the cross term or the difference is zero.
// Reset clears the trace sums, ring position, fill count and queue, and sets
// window_len to 50. When m_axis stalls the result is held; the queue fills
// and then s_axis tready drops on the next last trace.
module windowed_principal_axis_angle_unit import wpaa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [15:0] intercept, [31:16] gradient
	input  logic        s_axis_tlast,  // last_trace
	input  logic [2:0]  s_axis_tuser,  // [0] intercept_missing, [1] gradient_missing, [2] clear
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [15:0] angle
	output logic [0:0]  m_axis_tuser,  // [0] window_full
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data       // window_len
);

	logic [WLEN_BITS-1:0]          window_len_q;
	logic                          push_valid;
	logic                          push_ready;
	q_entry_t                      push_entry;
	logic                          pop_valid;
	logic                          pop_ready;
	q_entry_t                      pop_entry;
	logic [1:0]                    q_count;
	logic signed [ANGLE_BITS-1:0]  angle;

	// Window length register.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= WLEN_BITS'(WLEN_RESET);
		end else if (cfg_valid && cfg_ready) begin
			window_len_q <= cfg_data;
		end
	end

	wpaa_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (s_axis_tvalid),
		.in_ready          (s_axis_tready),
		.intercept         (s_axis_tdata[15:0]),
		.gradient          (s_axis_tdata[31:16]),
		.intercept_missing (s_axis_tuser[0]),
		.gradient_missing  (s_axis_tuser[1]),
		.last_trace        (s_axis_tlast),
		.clear             (s_axis_tuser[2]),
		.push_valid        (push_valid),
		.push_ready        (push_ready),
		.push_entry        (push_entry)
	);

	wpaa_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (push_valid),
		.wr_ready (push_ready),
		.wr_entry (push_entry),
		.rd_valid (pop_valid),
		.rd_ready (pop_ready),
		.rd_entry (pop_entry),
		.count    (q_count)
	);

	wpaa_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.window_len (window_len_q),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_angle  (angle),
		.out_full   (m_axis_tuser[0])
	);

	assign m_axis_tdata = angle;

	// The sample queue never counts past its two slots.
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count != 2'd3)
		else $error("sample queue count out of range");

	// A delivered angle stays within plus or minus ninety degrees.
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ($signed(m_axis_tdata) >= -16'sd23040 &&
			$signed(m_axis_tdata) <= 16'sd23040))
		else $error("angle out of range");

	// A one-sample window is full as soon as any sample has entered.
	a_short_window_full: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (window_len_q == 8'd1 || window_len_q == 8'd0))
			|-> m_axis_tuser[0])
		else $error("one-sample window not flagged full");

endmodule

@@ src/wpaa_front.sv @@
module wpaa_front import wpaa_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] intercept,
	input  logic signed [SAMPLE_BITS-1:0] gradient,
	input  logic                          intercept_missing,
	input  logic                          gradient_missing,
	input  logic                          last_trace,
	input  logic                          clear,
	output logic                          push_valid,
	input  logic                          push_ready,
	output q_entry_t                      push_entry
);

	logic                         v_s1;
	logic [SQP_BITS-1:0]          pa_s1;
	logic [SQP_BITS-1:0]          pb_s1;
	logic signed [PRODP_BITS-1:0] pp_s1;
	logic                         last_s1;
	logic                         clear_s1;

	logic [SQ_BITS-1:0]          acc_a_q;
	logic [SQ_BITS-1:0]          acc_b_q;
	logic signed [PROD_BITS-1:0] acc_p_q;
	logic                        clr_pend_q;

	logic signed [SAMPLE_BITS-1:0] a_op;
	logic signed [SAMPLE_BITS-1:0] b_op;
	logic                          advance;
	logic [SQ_BITS:0]              sum_a;
	logic [SQ_BITS:0]              sum_b;
	logic signed [PROD_BITS:0]     sum_p;
	logic [SQ_BITS-1:0]            new_a;
	logic [SQ_BITS-1:0]            new_b;
	logic signed [PROD_BITS-1:0]   new_p;

	// A missing sample enters the products as zero.
	assign a_op = intercept_missing ? '0 : intercept;
	assign b_op = gradient_missing  ? '0 : gradient;

	// The stage holds a last trace until the queue takes the sample.
	assign advance  = v_s1 && (!last_s1 || push_ready);
	assign in_ready = !v_s1 || advance;

	// Product stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			pa_s1    <= SQP_BITS'(a_op * a_op);
			pb_s1    <= SQP_BITS'(b_op * b_op);
			pp_s1    <= PRODP_BITS'(a_op * b_op);
			last_s1  <= last_trace;
			clear_s1 <= clear;
		end
	end

	// Saturating trace accumulation.
	always_comb begin
		sum_a = {1'b0, acc_a_q} + (SQ_BITS + 1)'(pa_s1);
		sum_b = {1'b0, acc_b_q} + (SQ_BITS + 1)'(pb_s1);
		sum_p = (PROD_BITS + 1)'(acc_p_q) + (PROD_BITS + 1)'(pp_s1);
		new_a = sum_a[SQ_BITS] ? SQ_MAX : sum_a[SQ_BITS-1:0];
		new_b = sum_b[SQ_BITS] ? SQ_MAX : sum_b[SQ_BITS-1:0];
		priority if (sum_p > (PROD_BITS + 1)'(PROD_MAX)) begin
			new_p = PROD_MAX;
		end else if (sum_p < (PROD_BITS + 1)'(PROD_MIN)) begin
			new_p = PROD_MIN;
		end else begin
			new_p = sum_p[PROD_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_a_q    <= '0;
			acc_b_q    <= '0;
			acc_p_q    <= '0;
			clr_pend_q <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				acc_a_q    <= '0;
				acc_b_q    <= '0;
				acc_p_q    <= '0;
				clr_pend_q <= 1'b0;
			end else begin
				acc_a_q    <= new_a;
				acc_b_q    <= new_b;
				acc_p_q    <= new_p;
				clr_pend_q <= clr_pend_q | clear_s1;
			end
		end
	end

	// A clear seen anywhere in the sample travels with its push.
	assign push_valid      = v_s1 && last_s1;
	assign push_entry.sq_a = new_a;
	assign push_entry.sq_b = new_b;
	assign push_entry.prod = new_p;
	assign push_entry.clr  = clr_pend_q | clear_s1;

endmodule

@@ src/wpaa_queue.sv @@
module wpaa_queue import wpaa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr_valid,
	output logic     wr_ready,
	input  q_entry_t wr_entry,
	output logic     rd_valid,
	input  logic     rd_ready,
	output q_entry_t rd_entry,
	output logic [1:0] count
);

	q_entry_t   slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_wr;
	logic       do_rd;

	assign wr_ready = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;
	assign rd_entry = slot_q[rd_ptr_q];
	assign count    = count_q;

	// Two-entry buffer between the trace front and the window back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(do_wr) - 2'(do_rd);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_entry;
		end
	end

endmodule

@@ src/wpaa_back.sv @@
module wpaa_back import wpaa_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [WLEN_BITS-1:0]         window_len,
	input  logic                         pop_valid,
	output logic                         pop_ready,
	input  q_entry_t                     pop_entry,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [ANGLE_BITS-1:0] out_angle,
	output logic                         out_full
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SUM   = 3'd1;
	localparam logic [2:0] ST_PREP  = 3'd2;
	localparam logic [2:0] ST_CHECK = 3'd3;
	localparam logic [2:0] ST_NORM  = 3'd4;
	localparam logic [2:0] ST_ROT   = 3'd5;
	localparam logic [2:0] ST_FIN   = 3'd6;

	localparam logic [XY_BITS-1:0] M_HIGH = XY_BITS'(64'd1 << 29);
	localparam logic [XY_BITS-1:0] M_LOW  = XY_BITS'(64'd1 << 28);

	q_entry_t ring_mem [MAX_WINDOW];
	q_entry_t rdata_q;

	logic [2:0]                  state_q;
	logic [POS_BITS-1:0]         pos_q;
	logic [FILL_BITS-1:0]        fill_q;
	logic [FILL_BITS-1:0]        issue_q;
	logic [POS_BITS-1:0]         rd_idx_q;
	logic                        rvalid_q;
	logic [WSQ_BITS-1:0]         sum_a_q;
	logic [WSQ_BITS-1:0]         sum_b_q;
	logic signed [WPROD_BITS-1:0] sum_p_q;
	logic signed [XY_BITS-1:0]   x_q;
	logic signed [XY_BITS-1:0]   y_q;
	logic [XY_BITS-1:0]          m_q;
	logic signed [Z_BITS-1:0]    z_q;
	logic [STEP_BITS-1:0]        step_q;
	logic                        full_q;
	logic                        out_valid_q;
	logic signed [ANGLE_BITS-1:0] out_angle_q;
	logic                        out_full_q;

	logic                        pop;
	logic                        mem_rd;
	logic [POS_BITS-1:0]         pos_use;
	logic [FILL_BITS-1:0]        fill_base;
	logic [FILL_BITS-1:0]        fill_new;
	logic [FILL_BITS-1:0]        w_eff;
	logic [FILL_BITS-1:0]        cnt;
	logic [XY_BITS-1:0]          mag_x;
	logic [XY_BITS-1:0]          mag_y;
	logic signed [XY_BITS-1:0]   shx;
	logic signed [XY_BITS-1:0]   shy;
	logic signed [Z_BITS-1:0]    z_rnd;
	logic signed [Z_BITS-1:0]    z_div;
	logic signed [ANGLE_BITS-1:0] angle_c;
	logic                        out_free;

	assign pop_ready = (state_q == ST_IDLE);
	assign pop       = pop_valid && pop_ready;
	assign mem_rd    = (state_q == ST_SUM) && (issue_q != '0);
	assign out_free  = !out_valid_q || out_ready;

	// Ring position, fill count and effective window for the incoming sample.
	always_comb begin
		pos_use   = pop_entry.clr ? '0 : pos_q;
		fill_base = pop_entry.clr ? '0 : fill_q;
		fill_new  = (fill_base == FILL_BITS'(MAX_WINDOW)) ? fill_base : fill_base + 1'b1;
		priority if (window_len == '0) begin
			w_eff = FILL_BITS'(1);
		end else if (FILL_BITS'(window_len) > FILL_BITS'(MAX_WINDOW)) begin
			w_eff = FILL_BITS'(MAX_WINDOW);
		end else begin
			w_eff = FILL_BITS'(window_len);
		end
		cnt = (w_eff < fill_new) ? w_eff : fill_new;
	end

	// CORDIC helpers and final rounding.
	always_comb begin
		mag_x   = x_q[XY_BITS-1] ? XY_BITS'(-x_q) : XY_BITS'(x_q);
		mag_y   = y_q[XY_BITS-1] ? XY_BITS'(-y_q) : XY_BITS'(y_q);
		shx     = x_q >>> step_q;
		shy     = y_q >>> step_q;
		z_rnd   = z_q + Z_BITS'(256);
		z_div   = z_rnd >>> 9;
		priority if (z_div > Z_BITS'(ANGLE_LIMIT)) begin
			angle_c = ANGLE_BITS'(ANGLE_LIMIT);
		end else if (z_div < -Z_BITS'(ANGLE_LIMIT)) begin
			angle_c = -ANGLE_BITS'(ANGLE_LIMIT);
		end else begin
			angle_c = z_div[ANGLE_BITS-1:0];
		end
	end

	// Ring storage: written on a push, read one older entry per cycle while summing.
	always_ff @(posedge clk) begin
		if (pop) begin
			ring_mem[pos_use] <= pop_entry;
		end
		if (mem_rd) begin
			rdata_q <= ring_mem[rd_idx_q];
		end
	end

	// Sequencer: window sum, set-up, normalize and rotate unless skipped, round.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			fill_q      <= '0;
			issue_q     <= '0;
			rd_idx_q    <= '0;
			rvalid_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						pos_q    <= pos_use + 1'b1;
						fill_q   <= fill_new;
						rd_idx_q <= pos_use - 1'b1;
						issue_q  <= cnt - 1'b1;
						sum_a_q  <= WSQ_BITS'(pop_entry.sq_a);
						sum_b_q  <= WSQ_BITS'(pop_entry.sq_b);
						sum_p_q  <= WPROD_BITS'(pop_entry.prod);
						full_q   <= (fill_new >= w_eff);
						state_q  <= ST_SUM;
					end
				end
				ST_SUM: begin
					rvalid_q <= mem_rd;
					if (mem_rd) begin
						rd_idx_q <= rd_idx_q - 1'b1;
						issue_q  <= issue_q - 1'b1;
					end
					if (rvalid_q) begin
						sum_a_q <= sum_a_q + WSQ_BITS'(rdata_q.sq_a);
						sum_b_q <= sum_b_q + WSQ_BITS'(rdata_q.sq_b);
						sum_p_q <= sum_p_q + WPROD_BITS'(rdata_q.prod);
					end
					if (!mem_rd && !rvalid_q) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					x_q     <= XY_BITS'(sum_a_q) - XY_BITS'(sum_b_q);
					y_q     <= XY_BITS'(sum_p_q) <<< 1;
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					priority if (y_q == '0) begin
						z_q     <= x_q[XY_BITS-1] ? Z_DEG180 : '0;
						state_q <= ST_FIN;
					end else if (x_q == '0) begin
						z_q     <= y_q[XY_BITS-1] ? -Z_DEG90 : Z_DEG90;
						state_q <= ST_FIN;
					end else begin
						m_q     <= (mag_x > mag_y) ? mag_x : mag_y;
						state_q <= ST_NORM;
					end
				end
				ST_NORM: begin
					priority if (m_q >= M_HIGH) begin
						x_q <= x_q >>> 1;
						y_q <= y_q >>> 1;
						m_q <= m_q >> 1;
					end else if (m_q < M_LOW) begin
						x_q <= x_q <<< 1;
						y_q <= y_q <<< 1;
						m_q <= m_q << 1;
					end else begin
						if (x_q[XY_BITS-1]) begin
							z_q <= y_q[XY_BITS-1] ? -Z_DEG180 : Z_DEG180;
							x_q <= -x_q;
							y_q <= -y_q;
						end else begin
							z_q <= '0;
						end
						step_q  <= '0;
						state_q <= ST_ROT;
					end
				end
				ST_ROT: begin
					if (!y_q[XY_BITS-1]) begin
						x_q <= x_q + shy;
						y_q <= y_q - shx;
						z_q <= z_q + atan_step(step_q);
					end else begin
						x_q <= x_q - shy;
						y_q <= y_q + shx;
						z_q <= z_q - atan_step(step_q);
					end
					if (step_q == STEP_BITS'(CORDIC_STEPS - 1)) begin
						state_q <= ST_FIN;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register holds the result while the receiver stalls.
	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			out_angle_q <= angle_c;
			out_full_q  <= full_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_angle = out_angle_q;
	assign out_full  = out_full_q;

endmodule
